// ----- rtl/core/magic_header_length_deframer_top_assert.svh -----
// Assertion macros used by the deframer RTL.
`ifndef MAGIC_HEADER_LENGTH_DEFRAMER_TOP_ASSERT_SVH
`define MAGIC_HEADER_LENGTH_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define MHLD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define MHLD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

// ----- rtl/core/mhld_pkg.sv -----
// Types and constants of the magic-header length deframer.
package mhld_pkg;

    // Size of the id bitmap; ids at or above this are never wanted.
    localparam int NUM_TRACKED_IDS = 256;
    localparam int NUM_CFG_REGS    = 4;
    localparam int CFG_WIDTH       = 64;
    localparam int CFG_IDX_W       = $clog2(NUM_CFG_REGS);
    localparam int HEADER_BYTES    = 8;
    localparam int HDR_CNT_W       = $clog2(HEADER_BYTES);

    localparam logic [7:0] MAGIC_FIRST  = 8'h50;
    localparam logic [7:0] MAGIC_SECOND = 8'h53;

    // Header byte positions.
    localparam logic [HDR_CNT_W-1:0] HDR_MAGIC0 = HDR_CNT_W'(0);
    localparam logic [HDR_CNT_W-1:0] HDR_MAGIC1 = HDR_CNT_W'(1);
    localparam logic [HDR_CNT_W-1:0] HDR_ID_HI  = HDR_CNT_W'(2);
    localparam logic [HDR_CNT_W-1:0] HDR_ID_LO  = HDR_CNT_W'(3);
    localparam logic [HDR_CNT_W-1:0] HDR_LAST   = HDR_CNT_W'(HEADER_BYTES - 1);

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_BODY    = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_FRAMING = 2'd2
    } t_kind;

    // One result item.
    typedef struct packed {
        t_kind       kind;
        logic [15:0] block_id;
        logic [7:0]  data_byte;
        logic [31:0] byte_offset;
        logic        last;
    } t_result;

endpackage

// ----- rtl/core/magic_header_length_deframer_top.sv -----
// Byte-stream deframer: header parse, id filter and result output stage.
// The result of an input byte transfer is registered in the output register, or in the skid entry if that is held.
// Throughput: one byte per cycle while s_axis_tready is high; the parser state registers close a loop.
// A two-entry output (register plus skid) keeps input accepted while a result waits.
// Reset is synchronous, active low: parser state, id bitmap and output valids clear.
`include "magic_header_length_deframer_top_assert.svh"

module magic_header_length_deframer_top
    import mhld_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_WIDTH-1:0] i_cfg_wdata,
    // Input byte stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
    // Result stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [55:0]          m_axis_tdata,   // [15:0] block_id, [23:16] data_byte,
                                                 // [55:24] byte_offset
    output logic [1:0]           m_axis_tuser,   // [1:0] kind
    output logic                 m_axis_tlast    // last
);

    // Configuration bitmap.
    logic [CFG_WIDTH-1:0] r_wanted [NUM_CFG_REGS];
    logic [NUM_CFG_REGS*CFG_WIDTH-1:0] wanted_flat;

    // Parser state.
    logic                 r_in_body,      n_in_body;
    logic [HDR_CNT_W-1:0] r_header_count, n_header_count;
    logic                 r_magic_ok,     n_magic_ok;
    logic [15:0]          r_current_id,   n_current_id;
    logic [31:0]          r_length_shift, n_length_shift;
    logic [31:0]          r_remaining,    n_remaining;
    logic [31:0]          r_offset_count, n_offset_count;
    logic                 r_body_wanted,  n_body_wanted;

    // Output stage.
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;

    logic    in_fire, out_fire;
    logic    res_valid;
    t_result res;
    logic    id_wanted;

    // Conditions used by the checks at the end.
    logic    out_framing, out_empty, body_state_ok;

    assign s_axis_tready = !r_skid_valid;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = r_out_valid && m_axis_tready;

    // Bitmap writes; indexes beyond the list cannot be encoded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CFG_REGS; i++) begin
                r_wanted[i] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            r_wanted[i_cfg_index] <= i_cfg_wdata;
        end
    end

    // Id lookup in the flattened bitmap; the id is complete by the last header byte.
    always_comb begin
        for (int i = 0; i < NUM_CFG_REGS; i++) begin
            wanted_flat[i*CFG_WIDTH +: CFG_WIDTH] = r_wanted[i];
        end
        id_wanted = (32'(r_current_id) < 32'(NUM_TRACKED_IDS))
                    && wanted_flat[r_current_id[$clog2(NUM_TRACKED_IDS)-1:0]];
    end

    // Parser next state and result for the byte in flight.
    always_comb begin
        n_in_body      = r_in_body;
        n_header_count = r_header_count;
        n_magic_ok     = r_magic_ok;
        n_current_id   = r_current_id;
        n_length_shift = r_length_shift;
        n_remaining    = r_remaining;
        n_offset_count = r_offset_count;
        n_body_wanted  = r_body_wanted;
        res_valid      = 1'b0;
        res            = '{kind: KIND_BODY, block_id: r_current_id, data_byte: s_axis_tdata,
                           byte_offset: r_offset_count, last: (r_remaining == 32'd1)};

        if (r_in_body) begin
            // Body byte: count it off and emit it if the id is wanted.
            res_valid      = r_body_wanted;
            n_remaining    = r_remaining - 32'd1;
            n_offset_count = r_offset_count + 32'd1;
            if (n_remaining == 32'd0) begin
                n_in_body      = 1'b0;
                n_header_count = HDR_MAGIC0;
                n_magic_ok     = 1'b1;
            end
        end else begin
            // Header byte: capture its field.
            unique case (r_header_count)
                HDR_MAGIC0: n_magic_ok = (s_axis_tdata == MAGIC_FIRST);
                HDR_MAGIC1: n_magic_ok = r_magic_ok && (s_axis_tdata == MAGIC_SECOND);
                HDR_ID_HI:  n_current_id = {s_axis_tdata, 8'h00};
                HDR_ID_LO:  n_current_id = {r_current_id[15:8], s_axis_tdata};
                default:    n_length_shift = {r_length_shift[23:0], s_axis_tdata};
            endcase

            if (r_header_count != HDR_LAST) begin
                n_header_count = r_header_count + HDR_CNT_W'(1);
            end else begin
                // Last header byte: judge the magic, then emit a framing or empty result or open the body.
                n_header_count = HDR_MAGIC0;
                n_magic_ok     = 1'b1;
                if (!r_magic_ok) begin
                    res_valid = 1'b1;
                    res       = '{kind: KIND_FRAMING, block_id: r_current_id,
                                  data_byte: 8'h00, byte_offset: 32'd0, last: 1'b0};
                end else begin
                    n_body_wanted  = id_wanted;
                    n_offset_count = 32'd0;
                    n_remaining    = n_length_shift;
                    if (n_length_shift == 32'd0) begin
                        res_valid = id_wanted;
                        res       = '{kind: KIND_EMPTY, block_id: r_current_id,
                                      data_byte: 8'h00, byte_offset: 32'd0, last: 1'b1};
                    end else begin
                        n_in_body = 1'b1;
                    end
                end
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_body      <= 1'b0;
            r_header_count <= HDR_MAGIC0;
            r_magic_ok     <= 1'b1;
            r_current_id   <= '0;
            r_length_shift <= '0;
            r_remaining    <= '0;
            r_offset_count <= '0;
            r_body_wanted  <= 1'b0;
        end else if (in_fire) begin
            r_in_body      <= n_in_body;
            r_header_count <= n_header_count;
            r_magic_ok     <= n_magic_ok;
            r_current_id   <= n_current_id;
            r_length_shift <= n_length_shift;
            r_remaining    <= n_remaining;
            r_offset_count <= n_offset_count;
            r_body_wanted  <= n_body_wanted;
        end
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_fire) begin
            r_out_valid <= in_fire && res_valid;
        end else if (in_fire && res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || out_fire) begin
            r_out <= res;
        end else begin
            r_skid <= res;
        end
    end

    // Port packing.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.byte_offset, r_out.data_byte, r_out.block_id};
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;

    // Result kinds on the output and the body bookkeeping seen by the checks.
    assign out_framing   = r_out_valid && (r_out.kind == KIND_FRAMING);
    assign out_empty     = r_out_valid && (r_out.kind == KIND_EMPTY);
    assign body_state_ok = (r_remaining != 32'd0) && (r_header_count == HDR_MAGIC0);

    // Checks on the parser and the output stage.
    `MHLD_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid)
    `MHLD_ASSERT_NOW(a_body_has_bytes, r_in_body, body_state_ok)
    `MHLD_ASSERT_NOW(a_framing_not_last, out_framing, !r_out.last && (r_out.byte_offset == 32'd0))
    `MHLD_ASSERT_NOW(a_empty_is_last, out_empty, r_out.last && (r_out.data_byte == 8'h00))
    `MHLD_ASSERT_NEXT(a_skid_drains, r_skid_valid && m_axis_tready, !r_skid_valid && r_out_valid)

endmodule
